/* rtl/agt_pkg.sv */
// Shared types and constants of the adjacency matrix graph traversal block.
package agt_pkg;

   localparam int DEFAULT_VERTEX_COUNT = 32;
   localparam int VERTEX_BITS          = 5;
   localparam int MAX_RESULTS          = 32;
   localparam int COUNT_BITS           = 6;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_SELF = 1'b1;

   typedef enum logic [1:0] {
      CMD_CONNECT    = 2'd0,
      CMD_DISCONNECT = 2'd1,
      CMD_BFS        = 2'd2,
      CMD_DFS        = 2'd3
   } command_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_LOAD,
      OP_ROW_FROM,
      OP_ROW_CUR,
      OP_EDGE_WR,
      OP_EMIT_EDGE,
      OP_EMIT_START,
      OP_BFS_INIT,
      OP_BFS_DEQ,
      OP_BFS_ROW,
      OP_BFS_ENQ,
      OP_BFS_EMIT,
      OP_DFS_INIT,
      OP_DFS_PUSH,
      OP_DFS_POP,
      OP_DFS_RESTORE,
      OP_DFS_FINAL
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic is_edge;
      logic is_bfs;
      logic is_self;
      logic edge_ok;
      logic start_ok;
      logic out_free;
      logic bfs_enq_ok;
      logic bfs_last;
      logic dfs_push_ok;
      logic dfs_bottom;
   } dp_status_type;

endpackage

/* rtl/agt_dpath.sv */
// Datapath of the graph traversal block: edge matrix, work list, visited set and result register.
module agt_dpath #(
   parameter int VERTEX_COUNT = agt_pkg::DEFAULT_VERTEX_COUNT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [1:0]                        req_command,
   input  logic [agt_pkg::VERTEX_BITS-1:0]   req_from_vertex,
   input  logic [agt_pkg::VERTEX_BITS-1:0]   req_to_vertex,
   input  agt_pkg::dp_cmd_type               cmd,
   output agt_pkg::dp_status_type            status,
   input  logic                              rsp_stall,
   output logic                              rsp_valid,
   output logic [agt_pkg::VERTEX_BITS-1:0]   rsp_vertex,
   output logic                              rsp_status,
   output logic                              rsp_last
);

   localparam int VW = $clog2(VERTEX_COUNT);
   localparam int PW = $clog2(VERTEX_COUNT + 1);
   localparam int CW = agt_pkg::COUNT_BITS;
   localparam logic [VERTEX_COUNT-1:0] ROW_ONE = {{(VERTEX_COUNT-1){1'b0}}, 1'b1};

   agt_pkg::command_type                cmd_ff, cmd_in;
   logic [agt_pkg::VERTEX_BITS-1:0]     from_ff, from_in;
   logic [agt_pkg::VERTEX_BITS-1:0]     to_ff, to_in;

   logic [VERTEX_COUNT-1:0]             edge_mem [VERTEX_COUNT];
   logic [VERTEX_COUNT-1:0]             row_valid_ff, row_valid_in;
   logic [VERTEX_COUNT-1:0]             row_q_ff;

   logic [VW-1:0]                       list_v_mem [VERTEX_COUNT];
   logic [PW-1:0]                       list_s_mem [VERTEX_COUNT];
   logic [VW-1:0]                       list_v_q_ff;
   logic [PW-1:0]                       list_s_q_ff;

   logic [VERTEX_COUNT-1:0]             visited_ff, visited_in;
   logic [PW-1:0]                       head_ff, head_in;
   logic [PW-1:0]                       tail_ff, tail_in;
   logic [VW-1:0]                       cur_v_ff, cur_v_in;
   logic [PW-1:0]                       cur_j_ff, cur_j_in;
   logic [VW-1:0]                       pend_v_ff, pend_v_in;
   logic [CW-1:0]                       count_ff, count_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic [agt_pkg::VERTEX_BITS-1:0]     rsp_vertex_ff, rsp_vertex_in;
   logic                                rsp_status_ff, rsp_status_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic [VW-1:0]                       start_v, to_v;
   logic                                from_in_range, to_in_range;
   logic [VERTEX_COUNT-1:0]             scan_mask, cand;
   logic                                first_any;
   logic [VW-1:0]                       first_idx;
   logic                                tail_room, count_room, out_free, bfs_last;
   logic [PW-1:0]                       tail_m1, tail_m2;
   logic [VERTEX_COUNT-1:0]             edge_wr_row;

   logic                                row_rd_en;
   logic [VW-1:0]                       row_rd_addr;
   logic                                list_rd_en;
   logic [VW-1:0]                       list_rd_addr;
   logic                                list_v_we, list_s_we;
   logic [VW-1:0]                       list_wr_addr;
   logic [VW-1:0]                       list_v_wdata;
   logic [PW-1:0]                       list_s_wdata;

   assign start_v       = VW'(from_ff);
   assign to_v          = VW'(to_ff);
   assign from_in_range = 32'(from_ff) < VERTEX_COUNT;
   assign to_in_range   = 32'(to_ff) < VERTEX_COUNT;
   assign tail_room     = tail_ff < PW'(VERTEX_COUNT);
   assign count_room    = count_ff < CW'(agt_pkg::MAX_RESULTS);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign tail_m1       = tail_ff - PW'(1);
   assign tail_m2       = tail_ff - PW'(2);
   assign bfs_last      = (head_ff == tail_ff) || (count_ff == CW'(agt_pkg::MAX_RESULTS - 1));

   always_comb begin
      for (int i = 0; i < VERTEX_COUNT; i++) begin
         scan_mask[i] = (i >= int'(cur_j_ff));
      end
   end

   // Depth-first scans resume at the saved position; breadth-first takes the whole row.
   assign cand = (cmd_ff == agt_pkg::CMD_DFS) ? (row_q_ff & ~visited_ff & scan_mask)
                                               : (row_q_ff & ~visited_ff);

   always_comb begin
      first_any = |cand;
      first_idx = '0;
      for (int i = VERTEX_COUNT - 1; i >= 0; i--) begin
         if (cand[i]) begin
            first_idx = VW'(i);
         end
      end
   end

   assign edge_wr_row = (cmd_ff == agt_pkg::CMD_CONNECT) ? (row_q_ff | (ROW_ONE << to_v))
                                                          : (row_q_ff & ~(ROW_ONE << to_v));

   always_comb begin
      status.is_edge     = (cmd_ff == agt_pkg::CMD_CONNECT) ||
                           (cmd_ff == agt_pkg::CMD_DISCONNECT);
      status.is_bfs      = (cmd_ff == agt_pkg::CMD_BFS);
      status.is_self     = (from_ff == to_ff);
      status.edge_ok     = from_in_range && to_in_range;
      status.start_ok    = from_in_range;
      status.out_free    = out_free;
      status.bfs_enq_ok  = first_any && tail_room;
      status.bfs_last    = bfs_last;
      status.dfs_push_ok = first_any && tail_room && count_room;
      status.dfs_bottom  = (tail_ff == PW'(1));
   end

   always_comb begin
      cmd_in        = cmd_ff;
      from_in       = from_ff;
      to_in         = to_ff;
      row_valid_in  = row_valid_ff;
      visited_in    = visited_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      cur_v_in      = cur_v_ff;
      cur_j_in      = cur_j_ff;
      pend_v_in     = pend_v_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      row_rd_en     = 1'b0;
      row_rd_addr   = cur_v_ff;
      list_rd_en    = 1'b0;
      list_rd_addr  = head_ff[VW-1:0];
      list_v_we     = 1'b0;
      list_s_we     = 1'b0;
      list_wr_addr  = tail_ff[VW-1:0];
      list_v_wdata  = first_idx;
      list_s_wdata  = PW'(first_idx) + PW'(1);

      unique case (cmd.op)
         agt_pkg::OP_NONE: begin
         end
         agt_pkg::OP_LOAD: begin
            cmd_in  = agt_pkg::command_type'(req_command);
            from_in = req_from_vertex;
            to_in   = req_to_vertex;
         end
         agt_pkg::OP_ROW_FROM: begin
            row_rd_en   = 1'b1;
            row_rd_addr = start_v;
         end
         agt_pkg::OP_ROW_CUR: begin
            row_rd_en = 1'b1;
         end
         agt_pkg::OP_EDGE_WR: begin
            row_valid_in[start_v] = 1'b1;
         end
         agt_pkg::OP_EMIT_EDGE: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = '0;
            rsp_status_in = status.is_self ? agt_pkg::STATUS_SELF : agt_pkg::STATUS_OK;
            rsp_last_in   = 1'b1;
         end
         agt_pkg::OP_EMIT_START: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = from_ff;
            rsp_status_in = agt_pkg::STATUS_OK;
            rsp_last_in   = 1'b1;
         end
         agt_pkg::OP_BFS_INIT: begin
            visited_in   = ROW_ONE << start_v;
            list_v_we    = 1'b1;
            list_wr_addr = '0;
            list_v_wdata = start_v;
            head_in      = '0;
            tail_in      = PW'(1);
            count_in     = '0;
         end
         agt_pkg::OP_BFS_DEQ: begin
            list_rd_en = 1'b1;
            head_in    = head_ff + PW'(1);
         end
         agt_pkg::OP_BFS_ROW: begin
            row_rd_en   = 1'b1;
            row_rd_addr = list_v_q_ff;
            cur_v_in    = list_v_q_ff;
         end
         agt_pkg::OP_BFS_ENQ: begin
            visited_in = visited_ff | (ROW_ONE << first_idx);
            list_v_we  = 1'b1;
            tail_in    = tail_ff + PW'(1);
         end
         agt_pkg::OP_BFS_EMIT: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = agt_pkg::VERTEX_BITS'(cur_v_ff);
            rsp_status_in = agt_pkg::STATUS_OK;
            rsp_last_in   = bfs_last;
            count_in      = count_ff + CW'(1);
         end
         agt_pkg::OP_DFS_INIT: begin
            visited_in = ROW_ONE << start_v;
            cur_v_in   = start_v;
            cur_j_in   = '0;
            pend_v_in  = start_v;
            tail_in    = PW'(1);
            count_in   = CW'(1);
         end
         agt_pkg::OP_DFS_PUSH: begin
            // The previous vertex is known not to be the final one once a child is found.
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = agt_pkg::VERTEX_BITS'(pend_v_ff);
            rsp_status_in = agt_pkg::STATUS_OK;
            rsp_last_in   = 1'b0;
            pend_v_in     = first_idx;
            list_v_we     = 1'b1;
            list_s_we     = 1'b1;
            list_wr_addr  = tail_m1[VW-1:0];
            list_v_wdata  = cur_v_ff;
            cur_v_in      = first_idx;
            cur_j_in      = '0;
            visited_in    = visited_ff | (ROW_ONE << first_idx);
            tail_in       = tail_ff + PW'(1);
            count_in      = count_ff + CW'(1);
         end
         agt_pkg::OP_DFS_POP: begin
            list_rd_en   = 1'b1;
            list_rd_addr = tail_m2[VW-1:0];
            tail_in      = tail_m1;
         end
         agt_pkg::OP_DFS_RESTORE: begin
            row_rd_en   = 1'b1;
            row_rd_addr = list_v_q_ff;
            cur_v_in    = list_v_q_ff;
            cur_j_in    = list_s_q_ff;
         end
         agt_pkg::OP_DFS_FINAL: begin
            rsp_valid_in  = 1'b1;
            rsp_vertex_in = agt_pkg::VERTEX_BITS'(pend_v_ff);
            rsp_status_in = agt_pkg::STATUS_OK;
            rsp_last_in   = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Edge rows and work list storage with registered read data.
   always_ff @(posedge clock) begin
      if (cmd.op == agt_pkg::OP_EDGE_WR) begin
         edge_mem[start_v] <= edge_wr_row;
      end
      if (row_rd_en) begin
         row_q_ff <= row_valid_ff[row_rd_addr] ? edge_mem[row_rd_addr] : '0;
      end
      if (list_v_we) begin
         list_v_mem[list_wr_addr] <= list_v_wdata;
      end
      if (list_s_we) begin
         list_s_mem[list_wr_addr] <= list_s_wdata;
      end
      if (list_rd_en) begin
         list_v_q_ff <= list_v_mem[list_rd_addr];
         list_s_q_ff <= list_s_mem[list_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_valid_ff <= row_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      from_ff       <= from_in;
      to_ff         <= to_in;
      visited_ff    <= visited_in;
      head_ff       <= head_in;
      tail_ff       <= tail_in;
      cur_v_ff      <= cur_v_in;
      cur_j_ff      <= cur_j_in;
      pend_v_ff     <= pend_v_in;
      count_ff      <= count_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_vertex = rsp_vertex_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

/* rtl/agt_ctrl.sv */
// Controller state machine that sequences edge updates and traversals.
module agt_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  agt_pkg::dp_status_type status,
   output agt_pkg::dp_cmd_type    cmd
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_EDGE_RD,
      S_EDGE_WR,
      S_EDGE_EMIT,
      S_START_EMIT,
      S_BFS_INIT,
      S_BFS_DEQ,
      S_BFS_ROW,
      S_BFS_SCAN,
      S_BFS_EMIT,
      S_DFS_INIT,
      S_DFS_ROW,
      S_DFS_SCAN,
      S_DFS_RESTORE,
      S_DFS_FINAL
   } state_type;

   state_type state_ff;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd.op = agt_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE:        cmd.op = req_valid ? agt_pkg::OP_LOAD : agt_pkg::OP_NONE;
         S_DECODE:      cmd.op = agt_pkg::OP_NONE;
         S_EDGE_RD:     cmd.op = agt_pkg::OP_ROW_FROM;
         S_EDGE_WR:     cmd.op = agt_pkg::OP_EDGE_WR;
         S_EDGE_EMIT:   cmd.op = status.out_free ? agt_pkg::OP_EMIT_EDGE : agt_pkg::OP_NONE;
         S_START_EMIT:  cmd.op = status.out_free ? agt_pkg::OP_EMIT_START : agt_pkg::OP_NONE;
         S_BFS_INIT:    cmd.op = agt_pkg::OP_BFS_INIT;
         S_BFS_DEQ:     cmd.op = agt_pkg::OP_BFS_DEQ;
         S_BFS_ROW:     cmd.op = agt_pkg::OP_BFS_ROW;
         S_BFS_SCAN:    cmd.op = status.bfs_enq_ok ? agt_pkg::OP_BFS_ENQ : agt_pkg::OP_NONE;
         S_BFS_EMIT:    cmd.op = status.out_free ? agt_pkg::OP_BFS_EMIT : agt_pkg::OP_NONE;
         S_DFS_INIT:    cmd.op = agt_pkg::OP_DFS_INIT;
         S_DFS_ROW:     cmd.op = agt_pkg::OP_ROW_CUR;
         S_DFS_SCAN: begin
            if (status.dfs_push_ok) begin
               cmd.op = status.out_free ? agt_pkg::OP_DFS_PUSH : agt_pkg::OP_NONE;
            end else if (!status.dfs_bottom) begin
               cmd.op = agt_pkg::OP_DFS_POP;
            end
         end
         S_DFS_RESTORE: cmd.op = agt_pkg::OP_DFS_RESTORE;
         S_DFS_FINAL:   cmd.op = status.out_free ? agt_pkg::OP_DFS_FINAL : agt_pkg::OP_NONE;
         default:       cmd.op = agt_pkg::OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_DECODE;
            end
            S_DECODE: begin
               if (status.is_edge) begin
                  state_ff <= (!status.is_self && status.edge_ok) ? S_EDGE_RD : S_EDGE_EMIT;
               end else if (!status.start_ok) begin
                  state_ff <= S_START_EMIT;
               end else begin
                  state_ff <= status.is_bfs ? S_BFS_INIT : S_DFS_INIT;
               end
            end
            S_EDGE_RD:     state_ff <= S_EDGE_WR;
            S_EDGE_WR:     state_ff <= S_EDGE_EMIT;
            S_EDGE_EMIT: begin
               if (status.out_free) state_ff <= S_IDLE;
            end
            S_START_EMIT: begin
               if (status.out_free) state_ff <= S_IDLE;
            end
            S_BFS_INIT:    state_ff <= S_BFS_DEQ;
            S_BFS_DEQ:     state_ff <= S_BFS_ROW;
            S_BFS_ROW:     state_ff <= S_BFS_SCAN;
            S_BFS_SCAN: begin
               if (!status.bfs_enq_ok) state_ff <= S_BFS_EMIT;
            end
            S_BFS_EMIT: begin
               if (status.out_free) state_ff <= status.bfs_last ? S_IDLE : S_BFS_DEQ;
            end
            S_DFS_INIT:    state_ff <= S_DFS_ROW;
            S_DFS_ROW:     state_ff <= S_DFS_SCAN;
            S_DFS_SCAN: begin
               if (status.dfs_push_ok) begin
                  if (status.out_free) state_ff <= S_DFS_ROW;
               end else if (status.dfs_bottom) begin
                  state_ff <= S_DFS_FINAL;
               end else begin
                  state_ff <= S_DFS_RESTORE;
               end
            end
            S_DFS_RESTORE: state_ff <= S_DFS_SCAN;
            S_DFS_FINAL: begin
               if (status.out_free) state_ff <= S_IDLE;
            end
            default:       state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* rtl/adjacency_matrix_graph_traversal.sv */
// Top level of the adjacency matrix graph traversal block.
//
// This block holds a directed graph as one row of edge bits per source vertex and runs four
// commands: connect and disconnect set or clear one edge and give a single result (status
// reports a refused self edge), while breadth-first and depth-first traversals give one result
// per vertex reached, in visit order, with last set on the final one. Neighbors are always
// taken in ascending index order. A request is taken only while the controller is idle, so
// one command is in flight at a time, but the result register lets the next request transfer
// while an earlier result still waits on rsp_stall. An edge command goes through decode, the
// edge row read, the edge row write and its result; a refused or out-of-range one goes from
// decode straight to its result. A breadth-first traversal starts with decode and an init
// step, and for each visited vertex reads the work list and then the edge row, takes one
// scan step per neighbor it queues plus a closing scan step, and gives the result. A
// depth-first traversal starts with decode, init, an edge row read and a scan and ends with
// the final result; each descent is a scan step that gives a result and then an edge row
// read, and each return a pop and a restore step. In both, the pace is set by the registered
// reads of the edge row memory and the work list memory, one access each per cycle, and by
// the single first-unvisited-neighbor search that is shared by all steps. The edge rows
// carry one valid bit per row that reset clears at once, so there is no clearing pass and
// the block accepts requests right after reset.
module adjacency_matrix_graph_traversal #(
   parameter int VERTEX_COUNT = agt_pkg::DEFAULT_VERTEX_COUNT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [1:0]                      req_command,
   input  logic [agt_pkg::VERTEX_BITS-1:0] req_from_vertex,
   input  logic [agt_pkg::VERTEX_BITS-1:0] req_to_vertex,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [agt_pkg::VERTEX_BITS-1:0] rsp_vertex,
   output logic                            rsp_status,
   output logic                            rsp_last
);

   // Command and status between the sequencer and the datapath.
   agt_pkg::dp_cmd_type    dp_cmd;
   agt_pkg::dp_status_type dp_status;

   // The controller decides every step; the request transfers while it sits idle.
   agt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (dp_status),
      .cmd       (dp_cmd)
   );

   // The datapath owns the edge memory, the queue or stack, and the result register.
   agt_dpath #(
      .VERTEX_COUNT (VERTEX_COUNT)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_command     (req_command),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .cmd             (dp_cmd),
      .status          (dp_status),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_vertex      (rsp_vertex),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

endmodule

/* tb/sv/tb_adjacency_matrix_graph_traversal.sv */
// Self-checking testbench for the adjacency matrix graph traversal block.
`timescale 1ns / 1ps

module tb_adjacency_matrix_graph_traversal;

   localparam int VERTICES      = agt_pkg::DEFAULT_VERTEX_COUNT;
   localparam int RANDOM_ITEMS  = 258;
   // The final stretch of the run goes without any idling on either side.
   localparam int CALM_ITEMS    = 40;
   localparam int DRAIN_CYCLES  = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int DIRECTED_ROWS = 22;

   // One result transfer as the block presents it.
   typedef struct packed {
      logic [agt_pkg::VERTEX_BITS-1:0] vertex;
      logic                            status;
      logic                            last;
   } visit_result_type;

   // One row of the directed stimulus. Where typed is set, the single result of the
   // row is written out here and the predictor only keeps the graph up to date.
   typedef struct packed {
      agt_pkg::command_type            cmd;
      logic [agt_pkg::VERTEX_BITS-1:0] from_v;
      logic [agt_pkg::VERTEX_BITS-1:0] to_v;
      logic                            typed;
      logic [agt_pkg::VERTEX_BITS-1:0] want_vertex;
      logic                            want_status;
   } stim_row_type;

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   logic [1:0]                      req_command;
   logic [agt_pkg::VERTEX_BITS-1:0] req_from_vertex;
   logic [agt_pkg::VERTEX_BITS-1:0] req_to_vertex;
   logic                            rsp_valid;
   logic                            rsp_stall;
   logic [agt_pkg::VERTEX_BITS-1:0] rsp_vertex;
   logic                            rsp_status;
   logic                            rsp_last;

   // Side information that travels with the request payload, so that the request
   // monitor knows whether the transfer carries a typed-in expectation.
   logic                            row_typed;
   logic [agt_pkg::VERTEX_BITS-1:0] row_vertex;
   logic                            row_status;

   // The predictor's own copy of the graph: bit j of graph_rows[i] is the edge i -> j.
   logic [VERTICES-1:0]    graph_rows [VERTICES];
   visit_result_type       visit_order [$];
   visit_result_type       awaited_results [$];

   stim_row_type           directed_rows [DIRECTED_ROWS];
   int                     mismatch_count;
   int                     transfers_sent;
   int                     cycle_count;
   bit                     idling_on;

   adjacency_matrix_graph_traversal u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_command     (req_command),
      .req_from_vertex (req_from_vertex),
      .req_to_vertex   (req_to_vertex),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_vertex      (rsp_vertex),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Prints one line per mismatch and counts it.
   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch at cycle %0d: %s is %0d, expected %0d", cycle_count, what, got,
               want);
      mismatch_count++;
   endtask

   // Applies one command to the predicted graph and leaves its results, in order and
   // with last on the final one, in visit_order.
   task automatic predict_command(input agt_pkg::command_type cmd,
                                  input logic [agt_pkg::VERTEX_BITS-1:0] src,
                                  input logic [agt_pkg::VERTEX_BITS-1:0] dst);
      logic [VERTICES-1:0]             seen;
      logic [agt_pkg::VERTEX_BITS-1:0] frontier [$];
      logic [agt_pkg::VERTEX_BITS-1:0] path [$];
      int                              resume_at [$];
      logic [agt_pkg::VERTEX_BITS-1:0] here;
      int                              j;
      visit_order.delete();
      case (cmd)
         agt_pkg::CMD_CONNECT, agt_pkg::CMD_DISCONNECT: begin
            // A self edge is refused and leaves the graph alone.
            if (src == dst) begin
               visit_order.insert(visit_order.size(),
                                  visit_result_type'{5'd0, agt_pkg::STATUS_SELF, 1'b0});
            end else begin
               graph_rows[src][dst] = (cmd == agt_pkg::CMD_CONNECT);
               visit_order.insert(visit_order.size(),
                                  visit_result_type'{5'd0, agt_pkg::STATUS_OK, 1'b0});
            end
         end
         agt_pkg::CMD_BFS: begin
            // A vertex is marked when it is queued and reported when it leaves the queue.
            seen = '0;
            seen[src] = 1'b1;
            frontier.insert(frontier.size(), src);
            while (frontier.size() != 0 && visit_order.size() < agt_pkg::MAX_RESULTS) begin
               here = frontier.pop_front();
               visit_order.insert(visit_order.size(),
                                  visit_result_type'{here, agt_pkg::STATUS_OK, 1'b0});
               for (j = 0; j < VERTICES; j++) begin
                  if (graph_rows[here][j] && !seen[j]) begin
                     seen[j] = 1'b1;
                     frontier.insert(frontier.size(), 5'(j));
                  end
               end
            end
         end
         default: begin
            // Preorder walk with an explicit stack; each level remembers where its
            // neighbor scan stopped so that a return picks up the next candidate.
            seen = '0;
            seen[src] = 1'b1;
            visit_order.insert(visit_order.size(),
                               visit_result_type'{src, agt_pkg::STATUS_OK, 1'b0});
            path.insert(path.size(), src);
            resume_at.insert(resume_at.size(), 0);
            while (path.size() != 0) begin
               here = path[path.size()-1];
               for (j = resume_at[resume_at.size()-1]; j < VERTICES; j++) begin
                  if (graph_rows[here][j] && !seen[j]) break;
               end
               if (j < VERTICES && path.size() < VERTICES &&
                   visit_order.size() < agt_pkg::MAX_RESULTS) begin
                  resume_at[resume_at.size()-1] = j + 1;
                  seen[j] = 1'b1;
                  visit_order.insert(visit_order.size(),
                                     visit_result_type'{5'(j), agt_pkg::STATUS_OK, 1'b0});
                  path.insert(path.size(), 5'(j));
                  resume_at.insert(resume_at.size(), 0);
               end else begin
                  void'(path.pop_back());
                  void'(resume_at.pop_back());
               end
            end
         end
      endcase
      visit_order[visit_order.size()-1].last = 1'b1;
   endtask

   // Presents one request and returns in the time step of the edge that accepts it.
   // The valid stays high into the next call unless that call opens a gap.
   task automatic send_item(input agt_pkg::command_type cmd,
                            input logic [agt_pkg::VERTEX_BITS-1:0] src,
                            input logic [agt_pkg::VERTEX_BITS-1:0] dst, input logic typed,
                            input logic [agt_pkg::VERTEX_BITS-1:0] want_vertex,
                            input logic want_status);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_command     <= cmd;
      req_from_vertex <= src;
      req_to_vertex   <= dst;
      row_typed       <= typed;
      row_vertex      <= want_vertex;
      row_status      <= want_status;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      transfers_sent++;
   endtask

   // Random edge command or traversal, with connects favored so the graph fills up
   // and traversals grow long over the run.
   task automatic send_random_item();
      agt_pkg::command_type            cmd;
      logic [agt_pkg::VERTEX_BITS-1:0] src;
      logic [agt_pkg::VERTEX_BITS-1:0] dst;
      int                              pick;
      pick = $urandom_range(0, 19);
      if (pick < 9)       cmd = agt_pkg::CMD_CONNECT;
      else if (pick < 13) cmd = agt_pkg::CMD_DISCONNECT;
      else if (pick < 16) cmd = agt_pkg::CMD_BFS;
      else                cmd = agt_pkg::CMD_DFS;
      src = 5'($urandom_range(0, VERTICES - 1));
      dst = ($urandom_range(0, 9) == 0) ? src : 5'($urandom_range(0, VERTICES - 1));
      send_item(cmd, src, dst, 1'b0, 5'd0, agt_pkg::STATUS_OK);
   endtask

   // Connects a random path and then walks it, which gives deep descents and returns.
   task automatic send_chain();
      logic [agt_pkg::VERTEX_BITS-1:0] head;
      logic [agt_pkg::VERTEX_BITS-1:0] prev;
      logic [agt_pkg::VERTEX_BITS-1:0] next_v;
      int                              links;
      links = $urandom_range(2, 8);
      head  = 5'($urandom_range(0, VERTICES - 1));
      prev  = head;
      repeat (links) begin
         next_v = 5'(prev + $urandom_range(1, VERTICES - 1));
         send_item(agt_pkg::CMD_CONNECT, prev, next_v, 1'b0, 5'd0, agt_pkg::STATUS_OK);
         prev = next_v;
      end
      send_item($urandom_range(0, 1) ? agt_pkg::CMD_DFS : agt_pkg::CMD_BFS, head, 5'd0,
                1'b0, 5'd0, agt_pkg::STATUS_OK);
   endtask

   // Closes a cycle through every vertex with an odd stride, so that both traversals
   // reach all vertices and give the largest number of results.
   task automatic send_full_ring();
      logic [agt_pkg::VERTEX_BITS-1:0] base;
      logic [agt_pkg::VERTEX_BITS-1:0] stride;
      logic [agt_pkg::VERTEX_BITS-1:0] start;
      int                              i;
      base   = 5'($urandom_range(0, VERTICES - 1));
      stride = 5'(2 * $urandom_range(0, VERTICES / 2 - 1) + 1);
      for (i = 0; i < VERTICES; i++) begin
         send_item(agt_pkg::CMD_CONNECT, 5'(base + i * stride), 5'(base + (i + 1) * stride),
                   1'b0, 5'd0, agt_pkg::STATUS_OK);
      end
      start = 5'($urandom_range(0, VERTICES - 1));
      send_item(agt_pkg::CMD_BFS, start, 5'd0, 1'b0, 5'd0, agt_pkg::STATUS_OK);
      send_item(agt_pkg::CMD_DFS, start, 5'd0, 1'b0, 5'd0, agt_pkg::STATUS_OK);
   endtask

   // Request monitor. Every accepted transfer goes through the predictor so the graph
   // copy stays in step; typed rows then replace the predicted result with their own.
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_command(agt_pkg::command_type'(req_command), req_from_vertex, req_to_vertex);
         if (row_typed) begin
            awaited_results.insert(awaited_results.size(),
                                   visit_result_type'{row_vertex, row_status, 1'b1});
         end else begin
            foreach (visit_order[k]) awaited_results.insert(awaited_results.size(),
                                                            visit_order[k]);
         end
      end
   end

   // Result monitor: each accepted result is checked against the oldest expectation.
   always @(posedge clock) begin
      visit_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            report_mismatch("unexpected result, vertex", rsp_vertex, -1);
         end else begin
            want = awaited_results.pop_front();
            if (rsp_vertex !== want.vertex) report_mismatch("vertex", rsp_vertex, want.vertex);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
            if (rsp_last !== want.last)     report_mismatch("last", rsp_last, want.last);
         end
      end
   end

   // Result side stall: random bursts while idling is on, separated now and then by
   // longer stretches with no stall at all.
   initial begin
      int pick;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         pick = $urandom_range(0, 9);
         if (idling_on && !reset && pick < 3) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (pick == 3) begin
            repeat ($urandom_range(10, 40)) @(posedge clock);
         end
      end
   end

   // A run that hangs ends here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int row;
      int random_start;
      bit ring_sent;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_command     = agt_pkg::CMD_CONNECT;
      req_from_vertex = '0;
      req_to_vertex   = '0;
      row_typed       = 1'b0;
      row_vertex      = '0;
      row_status      = agt_pkg::STATUS_OK;
      mismatch_count  = 0;
      transfers_sent  = 0;
      cycle_count     = 0;
      idling_on       = 1'b1;
      ring_sent       = 1'b0;
      foreach (graph_rows[i]) graph_rows[i] = '0;

      // Directed part. The first rows run on the empty graph left by reset, then the
      // self edge refusals, idempotent set and clear, and a small graph with a back
      // edge and a cycle that both traversals must not revisit.
      directed_rows = '{
         '{agt_pkg::CMD_BFS,        5'd0,  5'd0,  1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_DFS,        5'd31, 5'd0,  1'b1, 5'd31, agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd5,  5'd5,  1'b1, 5'd0,  agt_pkg::STATUS_SELF},
         '{agt_pkg::CMD_DISCONNECT, 5'd31, 5'd31, 1'b1, 5'd0,  agt_pkg::STATUS_SELF},
         '{agt_pkg::CMD_DISCONNECT, 5'd0,  5'd31, 1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd0,  5'd31, 1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd0,  5'd31, 1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_BFS,        5'd0,  5'd0,  1'b0, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd31, 5'd0,  1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd0,  5'd1,  1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd1,  5'd2,  1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd0,  5'd2,  1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd2,  5'd30, 1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_BFS,        5'd0,  5'd31, 1'b0, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_DFS,        5'd0,  5'd31, 1'b0, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_DFS,        5'd31, 5'd0,  1'b0, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_BFS,        5'd30, 5'd0,  1'b0, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_DISCONNECT, 5'd0,  5'd1,  1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_DFS,        5'd0,  5'd0,  1'b0, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd21, 5'd10, 1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_CONNECT,    5'd10, 5'd21, 1'b1, 5'd0,  agt_pkg::STATUS_OK},
         '{agt_pkg::CMD_DFS,        5'd10, 5'd21, 1'b0, 5'd0,  agt_pkg::STATUS_OK}
      };

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (row = 0; row < DIRECTED_ROWS; row++) begin
         send_item(directed_rows[row].cmd, directed_rows[row].from_v, directed_rows[row].to_v,
                   directed_rows[row].typed, directed_rows[row].want_vertex,
                   directed_rows[row].want_status);
      end

      // Random part: mostly single commands, some connected paths that are walked
      // right away, and once a ring through all vertices for full-length traversals.
      random_start = transfers_sent;
      while (transfers_sent - random_start < RANDOM_ITEMS) begin
         idling_on = (transfers_sent - random_start < RANDOM_ITEMS - CALM_ITEMS);
         if (!ring_sent && transfers_sent - random_start >= RANDOM_ITEMS / 3) begin
            send_full_ring();
            ring_sent = 1'b1;
         end else if ($urandom_range(0, 9) == 0) begin
            send_chain();
         end else begin
            send_random_item();
         end
      end
      req_valid <= 1'b0;

      // Let every expected transfer arrive, then watch a little longer for strays.
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

/* adjacency_matrix_graph_traversal.f */
rtl/agt_pkg.sv
rtl/agt_dpath.sv
rtl/agt_ctrl.sv
rtl/adjacency_matrix_graph_traversal.sv
tb/sv/tb_adjacency_matrix_graph_traversal.sv
